/* rtl/core/fpa_pkg.sv */
// Shared types and constants for the Q24.8 fixed-point ALU pipeline.
`default_nettype none

package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_t;

  typedef struct packed {
    op_t                opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_req_t;

  typedef struct packed {
    logic signed [31:0] result_raw;
    logic               compare_true;
    logic               divide_by_zero;
  } fpa_rsp_t;

  // Restoring divide: one quotient bit per stage, 33 bits cover any unsaturated result
  localparam int DIV_STEPS = 33;
  localparam int QUO_W     = 33;

  localparam logic [31:0] MAG_SAT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0]      rem;
    logic [31:0]      dvsr;
    logic [QUO_W-1:0] dl;
    logic [QUO_W-1:0] quo;
  } fpa_div_t;

  // Control and result word that travels beside the datapath
  typedef struct packed {
    op_t         op;
    logic        neg;
    logic        cmp;
    logic        dz;
    logic        ovf;
    logic [31:0] res;
  } fpa_side_t;

endpackage

`default_nettype wire

/* rtl/core/fpa_div_step.sv */
// One registered stage of the restoring divider: one quotient bit per stage.
`default_nettype none

module fpa_div_step (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire fpa_pkg::fpa_div_t din,
  output fpa_pkg::fpa_div_t      dout
);
  import fpa_pkg::*;

  logic [32:0] ext;
  logic [33:0] diff;
  logic        ge;
  fpa_div_t    dout_next;

  always_comb begin
    ext  = {din.rem, din.dl[QUO_W-1]};
    diff = {1'b0, ext} - {2'b00, din.dvsr};
    ge   = ~diff[33];
    dout_next.dvsr = din.dvsr;
    dout_next.rem  = ge ? diff[31:0] : ext[31:0];
    dout_next.dl   = {din.dl[QUO_W-2:0], 1'b0};
    dout_next.quo  = {din.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fixed_point_alu_q24_8_core.sv */
// Top level of the pipelined signed fixed-point ALU.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  request | req_valid / req_ready  | req_data  (opcode, operand_a, operand_b)
//  result  | rsp_valid / rsp_ready  | rsp_data  (result_raw, compare_true,
//          |                        |            divide_by_zero)
//
//  Every opcode takes the same path, one request per cycle sustained while rsp_ready
//  lets results leave. The depth is set by the 33-stage restoring divider.
//  Reset clears the stage valid bits only; payload registers are left as they are.
//  A stage takes new data when it is empty or its successor moves, so bubbles
//  close up under a stall and a full pipeline holds every request in place.
`default_nettype none

module fixed_point_alu_q24_8_core #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire fpa_pkg::fpa_req_t req_data,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output fpa_pkg::fpa_rsp_t      rsp_data
);
  import fpa_pkg::*;

  localparam int S_IN   = 1;
  localparam int S_PREP = 2;
  localparam int S_MUL  = 3;
  localparam int S_RND  = S_MUL + DIV_STEPS;
  localparam int S_OUT  = S_RND + 1;

  logic      v  [S_IN:S_OUT];
  logic      en [S_IN:S_OUT];
  fpa_side_t sb [S_IN:S_RND];

  // ---------------- stage 1: decode, simple ops, magnitudes ----------------
  logic [31:0] a_u, b_u;
  logic        lt, gt, eq;
  logic [31:0] res1;
  logic        cmp1;
  fpa_side_t   sb1_next;
  logic [31:0] ma1, mb1;

  always_comb begin
    a_u = $unsigned(req_data.operand_a);
    b_u = $unsigned(req_data.operand_b);
    lt  = $signed(req_data.operand_a) < $signed(req_data.operand_b);
    gt  = $signed(req_data.operand_a) > $signed(req_data.operand_b);
    eq  = a_u == b_u;
    res1 = '0;
    cmp1 = 1'b0;
    case (req_data.opcode)
      OP_ADD:      res1 = a_u + b_u;
      OP_SUB:      res1 = a_u - b_u;
      OP_GT:       cmp1 = gt;
      OP_LT:       cmp1 = lt;
      OP_GE:       cmp1 = ~lt;
      OP_LE:       cmp1 = ~gt;
      OP_EQ:       cmp1 = eq;
      OP_NE:       cmp1 = ~eq;
      OP_MIN:      res1 = lt ? a_u : b_u;
      OP_MAX:      res1 = gt ? a_u : b_u;
      OP_INC:      res1 = a_u + 32'd1;
      OP_DEC:      res1 = a_u - 32'd1;
      OP_TO_INT:   res1 = $unsigned($signed(req_data.operand_a) >>> FRAC_BITS);
      OP_FROM_INT: res1 = a_u << FRAC_BITS;
      default:     res1 = '0;
    endcase
    sb1_next.op  = req_data.opcode;
    sb1_next.neg = a_u[31] ^ b_u[31];
    sb1_next.cmp = cmp1;
    sb1_next.dz  = (req_data.opcode == OP_DIV) && (b_u == 32'd0);
    sb1_next.ovf = 1'b0;
    sb1_next.res = res1;
  end

  always_ff @(posedge clk) begin
    if (en[S_IN]) begin
      sb[S_IN] <= sb1_next;
      ma1      <= a_u[31] ? (~a_u + 32'd1) : a_u;
      mb1      <= b_u[31] ? (~b_u + 32'd1) : b_u;
    end
  end

  // ---------------- stage 2: product, divider set-up ----------------
  logic [64:0] num_wide;
  logic [63:0] prod;
  fpa_div_t    dv_prep;
  fpa_side_t   sb2_next;

  always_comb begin
    // dividend is |a| * 2^(F+1); upper bits seed the remainder
    num_wide     = {33'b0, ma1} << (FRAC_BITS + 1);
    sb2_next     = sb[S_IN];
    sb2_next.ovf = num_wide[64:33] >= mb1;
  end

  always_ff @(posedge clk) begin
    if (en[S_PREP]) begin
      sb[S_PREP]   <= sb2_next;
      prod         <= ma1 * mb1;
      dv_prep.rem  <= num_wide[64:33];
      dv_prep.dvsr <= mb1;
      dv_prep.dl   <= num_wide[32:0];
      dv_prep.quo  <= '0;
    end
  end

  // ---------------- stage 3: multiply rounding ----------------
  logic [63:0] prod_sh;
  logic [31:0] mul_mag;
  fpa_side_t   sb3_next;

  always_comb begin
    prod_sh  = prod >> FRAC_BITS;
    mul_mag  = (|prod_sh[63:31]) ? MAG_SAT
                                 : prod_sh[31:0] + {31'b0, prod[FRAC_BITS-1]};
    sb3_next = sb[S_PREP];
    if (sb[S_PREP].op == OP_MUL) begin
      sb3_next.res = mul_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      sb[S_MUL] <= sb3_next;
    end
  end

  // ---------------- stages 3 .. 35: divider steps ----------------
  fpa_div_t dv [0:DIV_STEPS-1];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    if (k == 0) begin : g_first
      fpa_div_step u_step (
        .clk  (clk),
        .en   (en[S_MUL]),
        .din  (dv_prep),
        .dout (dv[k])
      );
    end else begin : g_next
      fpa_div_step u_step (
        .clk  (clk),
        .en   (en[S_MUL + k]),
        .din  (dv[k-1]),
        .dout (dv[k])
      );
      always_ff @(posedge clk) begin
        if (en[S_MUL + k]) begin
          sb[S_MUL + k] <= sb[S_MUL + k - 1];
        end
      end
    end
  end

  // ---------------- stage 36: divide rounding ----------------
  logic [QUO_W-1:0] quo;
  logic [32:0]      quo_inc;
  logic             div_big;
  logic [31:0]      div_mag;
  fpa_side_t        sbr_next;

  always_comb begin
    quo      = dv[DIV_STEPS-1].quo;
    // round half away: floor((Q + 1) / 2), saturate once it reaches 2^31
    quo_inc  = {1'b0, quo[31:0]} + 33'd1;
    div_big  = sb[S_RND-1].ovf | quo[QUO_W-1] | (&quo[31:0]);
    div_mag  = div_big ? MAG_SAT : quo_inc[32:1];
    sbr_next = sb[S_RND-1];
    if (sb[S_RND-1].op == OP_DIV) begin
      sbr_next.res = div_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_RND]) begin
      sb[S_RND] <= sbr_next;
    end
  end

  // ---------------- stage 37: sign, saturation, output register ----------------
  logic [31:0] mag;
  fpa_rsp_t    rsp_next;

  always_comb begin
    mag = sb[S_RND].res;
    rsp_next.compare_true   = sb[S_RND].cmp;
    rsp_next.divide_by_zero = sb[S_RND].dz;
    rsp_next.result_raw     = $signed(mag);
    if (sb[S_RND].op == OP_MUL || sb[S_RND].op == OP_DIV) begin
      if (sb[S_RND].dz) begin
        rsp_next.result_raw = '0;
      end else if (sb[S_RND].neg) begin
        rsp_next.result_raw = $signed(~mag + 32'd1);
      end else if (mag[31]) begin
        rsp_next.result_raw = $signed(POS_MAX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      rsp_data <= rsp_next;
    end
  end

  // ---------------- flow control ----------------
  always_comb begin
    en[S_OUT] = ~v[S_OUT] | rsp_ready;
    for (int s = S_OUT - 1; s >= S_IN; s--) begin
      en[s] = ~v[s] | en[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = S_IN; s <= S_OUT; s++) begin
        v[s] <= 1'b0;
      end
    end else begin
      if (en[S_IN]) begin
        v[S_IN] <= req_valid;
      end
      for (int s = S_IN + 1; s <= S_OUT; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  assign req_ready = en[S_IN];
  assign rsp_valid = v[S_OUT];

  // ---------------- assertions ----------------
  logic pipe_full;

  always_comb begin
    pipe_full = 1'b1;
    for (int s = S_IN; s <= S_OUT; s++) begin
      pipe_full = pipe_full & v[s];
    end
  end

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    pipe_full && !rsp_ready |-> !req_ready)
    else $error("request taken while pipeline full and result stalled");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.divide_by_zero |->
      rsp_data.result_raw == 32'sd0 && !rsp_data.compare_true)
    else $error("divide by zero with non-zero result");

  a_dz_div_only: assert property (@(posedge clk) disable iff (rst)
    v[S_RND] && sb[S_RND].dz |-> sb[S_RND].op == OP_DIV)
    else $error("divide-by-zero flag on a non-divide request");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v[S_RND-1] && sb[S_RND-1].op == OP_DIV && !sb[S_RND-1].ovf && !sb[S_RND-1].dz |->
      dv[DIV_STEPS-1].rem < dv[DIV_STEPS-1].dvsr)
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

/* verif/tb_fixed_point_alu_q24_8_core.sv */
// Self-checking testbench for the pipelined Q24.8 fixed-point ALU core.
`timescale 1ns / 1ps

module tb_fixed_point_alu_q24_8_core;
  import fpa_pkg::*;

  localparam int FRAC_BITS      = 8;
  localparam int RANDOM_ITEMS   = 600;
  localparam int HOLD_CYCLES    = 300;
  localparam int FLOOD_ITEMS    = 80;
  localparam int TAIL_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    fpa_req_t req;
    bit       typed;
    fpa_rsp_t rsp;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  fpa_req_t req_data = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  fpa_rsp_t rsp_data;

  fpa_rsp_t  pending_rsp_q[$];
  stim_row_t directed_q[$];
  fpa_rsp_t  want_rsp;
  int        mismatch_count = 0;
  int        sent_count = 0;
  int        checked_count = 0;
  int        idle_cycles = 0;
  bit        hold_off_go = 1'b0;

  fixed_point_alu_q24_8_core #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply sign to a magnitude and clamp to the signed 32-bit range
  function automatic logic [31:0] saturate_q(input logic [63:0] mag, input logic neg);
    logic [31:0] lo;
    lo = mag[31:0];
    if (neg) begin
      if (mag >= 64'h8000_0000) return 32'h8000_0000;
      return ~lo + 32'd1;
    end
    if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return lo;
  endfunction

  function automatic fpa_rsp_t predict_alu(input fpa_req_t r);
    logic [31:0] ua;
    logic [31:0] ub;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] mag;
    logic        neg;
    fpa_rsp_t    p;
    ua  = r.operand_a;
    ub  = r.operand_b;
    neg = ua[31] ^ ub[31];
    ma  = ua[31] ? 64'h1_0000_0000 - {32'd0, ua} : {32'd0, ua};
    mb  = ub[31] ? 64'h1_0000_0000 - {32'd0, ub} : {32'd0, ub};
    p   = '0;
    case (r.opcode)
      OP_ADD: p.result_raw = ua + ub;
      OP_SUB: p.result_raw = ua - ub;
      OP_MUL: begin
        mag = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        p.result_raw = saturate_q(mag, neg);
      end
      OP_DIV: begin
        if (ub == 32'd0) begin
          p.divide_by_zero = 1'b1;
        end else begin
          mag = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
          p.result_raw = saturate_q(mag, neg);
        end
      end
      OP_GT: p.compare_true = $signed(ua) >  $signed(ub);
      OP_LT: p.compare_true = $signed(ua) <  $signed(ub);
      OP_GE: p.compare_true = $signed(ua) >= $signed(ub);
      OP_LE: p.compare_true = $signed(ua) <= $signed(ub);
      OP_EQ: p.compare_true = ua == ub;
      OP_NE: p.compare_true = ua != ub;
      OP_MIN: p.result_raw = ($signed(ua) < $signed(ub)) ? ua : ub;
      OP_MAX: p.result_raw = ($signed(ua) > $signed(ub)) ? ua : ub;
      OP_INC: p.result_raw = ua + 32'd1;
      OP_DEC: p.result_raw = ua - 32'd1;
      OP_TO_INT: p.result_raw = $signed(ua) >>> FRAC_BITS;
      OP_FROM_INT: p.result_raw = ua << FRAC_BITS;
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] corners [8];
    corners = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h100, 32'hFFFF_FF00, 32'h80};
    case ($urandom_range(0, 9))
      0:       return corners[3'($urandom_range(0, 7))];
      1, 2, 3: return 32'($urandom_range(0, 8192)) - 32'd4096;
      4, 5:    return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input op_t op, input logic [31:0] a, input logic [31:0] b,
                         input bit typed, input fpa_rsp_t rsp);
    stim_row_t row;
    row.req.opcode    = op;
    row.req.operand_a = a;
    row.req.operand_b = b;
    row.typed         = typed;
    row.rsp           = rsp;
    directed_q.push_back(row);
  endtask

  // Call at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input fpa_req_t r, input bit typed, input fpa_rsp_t rsp);
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    pending_rsp_q.push_back(typed ? rsp : predict_alu(r));
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_random();
    fpa_req_t r;
    r.opcode    = op_t'($urandom_range(0, 15));
    r.operand_a = pick_operand();
    r.operand_b = pick_operand();
    send_request(r, 1'b0, '0);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Receiver: ready follows one of four randomly chosen patterns; a hold-off request overrides it
  initial begin
    int mode;
    int phase;
    mode  = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_off_go) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_go = 1'b0;
      end else begin
        if (phase % 48 == 0) mode = $urandom_range(0, 3);
        phase++;
        case (mode)
          0:       rsp_ready <= 1'b1;
          1:       rsp_ready <= 1'($urandom_range(0, 1));
          2:       rsp_ready <= (phase % 4 == 0);
          default: rsp_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: result with no request pending, actual %h", $time, rsp_data);
        mismatch_count++;
      end else begin
        want_rsp = pending_rsp_q.pop_front();
        checked_count++;
        if (rsp_data.result_raw !== want_rsp.result_raw) begin
          $display("%0t: result_raw mismatch, expected %h, actual %h",
                   $time, want_rsp.result_raw, rsp_data.result_raw);
          mismatch_count++;
        end
        if (rsp_data.compare_true !== want_rsp.compare_true) begin
          $display("%0t: compare_true mismatch, expected %b, actual %b",
                   $time, want_rsp.compare_true, rsp_data.compare_true);
          mismatch_count++;
        end
        if (rsp_data.divide_by_zero !== want_rsp.divide_by_zero) begin
          $display("%0t: divide_by_zero mismatch, expected %b, actual %b",
                   $time, want_rsp.divide_by_zero, rsp_data.divide_by_zero);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_rsp_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int  rand_sent;
    int  burst;
    bit  hold_done;
    bit  drain_done;
    rand_sent  = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;

    add_row(OP_ADD, 32'h7FFF_FFFF, 32'h1, 1'b1, '{32'h8000_0000, 1'b0, 1'b0});
    add_row(OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0});
    add_row(OP_SUB, 32'h8000_0000, 32'h1, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0});
    add_row(OP_MUL, 32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0});
    add_row(OP_MUL, 32'h8000_0000, 32'h100, 1'b1, '{32'h8000_0000, 1'b0, 1'b0});
    // exact halves round away from zero
    add_row(OP_MUL, 32'h1, 32'h80, 1'b0, '0);
    add_row(OP_MUL, 32'hFFFF_FFFF, 32'h80, 1'b0, '0);
    add_row(OP_DIV, 32'h500, 32'h0, 1'b1, '{32'h0, 1'b0, 1'b1});
    add_row(OP_DIV, 32'h8000_0000, 32'h0, 1'b1, '{32'h0, 1'b0, 1'b1});
    add_row(OP_DIV, 32'h1, 32'h200, 1'b0, '0);
    add_row(OP_DIV, 32'hFFFF_FFFF, 32'h200, 1'b0, '0);
    add_row(OP_DIV, 32'h8000_0000, 32'h1, 1'b0, '0);
    add_row(OP_GT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0, 1'b1, 1'b0});
    add_row(OP_LT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h0, 1'b1, 1'b0});
    add_row(OP_GE, 32'hFFFF_FFFB, 32'hFFFF_FFFB, 1'b1, '{32'h0, 1'b1, 1'b0});
    // le must hold on equality
    add_row(OP_LE, 32'h100, 32'h100, 1'b1, '{32'h0, 1'b1, 1'b0});
    add_row(OP_LE, 32'h101, 32'h100, 1'b1, '{32'h0, 1'b0, 1'b0});
    add_row(OP_EQ, 32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0, 1'b1, 1'b0});
    add_row(OP_NE, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 1'b0});
    add_row(OP_MIN, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0);
    add_row(OP_MAX, 32'hFFFF_FFFF, 32'h1, 1'b0, '0);
    add_row(OP_INC, 32'h7FFF_FFFF, 32'h0, 1'b1, '{32'h8000_0000, 1'b0, 1'b0});
    add_row(OP_DEC, 32'h8000_0000, 32'h0, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0});
    add_row(OP_TO_INT, 32'hFFFF_FFFF, 32'h0, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0});
    add_row(OP_FROM_INT, 32'h0080_0000, 32'h0, 1'b1, '{32'h8000_0000, 1'b0, 1'b0});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    if (rsp_valid !== 1'b0) begin
      $display("%0t: rsp_valid after reset, expected 0, actual %b", $time, rsp_valid);
      mismatch_count++;
    end

    foreach (directed_q[i]) begin
      send_request(directed_q[i].req, directed_q[i].typed, directed_q[i].rsp);
      idle_sender($urandom_range(0, 2));
    end

    while (rand_sent < RANDOM_ITEMS) begin
      if (!hold_done && rand_sent >= 150) begin
        // stall the output and keep offering requests until the input backs up
        hold_off_go = 1'b1;
        repeat (FLOOD_ITEMS) send_random();
        rand_sent += FLOOD_ITEMS;
        hold_done = 1'b1;
      end else if (!drain_done && rand_sent >= 400) begin
        req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(negedge clk);
        drain_done = 1'b1;
      end else begin
        burst = $urandom_range(1, 16);
        repeat (burst) send_random();
        rand_sent += burst;
        idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
    end

    req_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d requests across all 16 opcodes, %0d results checked, %0d mismatches",
             sent_count, checked_count, mismatch_count);
    $display("included an output hold-off of %0d cycles and a full drain pause", HOLD_CYCLES);
    if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
